[hdl/bes_pkg.sv]
package bes_pkg;

   localparam int WORD_W        = 32;
   localparam int DT_W          = 16;
   localparam int HALF_W        = 31;
   localparam int BOUNCE_W      = 17;
   localparam int BOUNCE_FRAC   = 16;
   localparam int DAMP_W        = 24;
   localparam int CSR_IDX_W     = 2;
   localparam int SAT_W         = 64;
   localparam int PROD_W        = DAMP_W + DT_W;
   localparam int MUL_DT_W      = WORD_W + DT_W + 1;
   localparam int BOUNCE_PROD_W = WORD_W + BOUNCE_W;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;
   localparam longint   WORD_MAX_L = 64'sd2147483647;
   localparam longint   WORD_MIN_L = -64'sd2147483648;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAVITY_X = 2'd0,
      CSR_GRAVITY_Y = 2'd1,
      CSR_GRAVITY_Z = 2'd2,
      CSR_TIME_STEP = 2'd3
   } csr_index_type;

   typedef struct packed {
      word_type            gravity_x;
      word_type            gravity_y;
      word_type            gravity_z;
      logic [DT_W-1:0]     time_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gravity_x: 32'sd0,
      gravity_y: -32'sd642908,
      gravity_z: 32'sd0,
      time_step: 16'd1092
   };

   typedef struct packed {
      logic                body_active;
      word_type [2:0]      pos;
      word_type [2:0]      vel;
      logic [HALF_W-1:0]   half_height;
      logic [BOUNCE_W-1:0] bounce_factor;
      logic [DAMP_W-1:0]   damping_rate;
   } body_in_type;

   typedef struct packed {
      logic                body_active;
      word_type [2:0]      pos;
      word_type [2:0]      vel;
      logic [HALF_W-1:0]   half_height;
      logic [BOUNCE_W-1:0] bounce_factor;
   } vel_out_type;

   typedef struct packed {
      word_type [2:0]      pos;
      word_type [2:0]      vel;
      logic                contact;
      logic [WORD_W-1:0]   speed;
      logic [BOUNCE_W-1:0] bounce_factor;
   } pos_out_type;

   typedef struct packed {
      word_type [2:0]      pos;
      word_type [2:0]      vel;
      logic                floor_contact;
      logic [HALF_W-1:0]   impact_speed;
   } rsp_out_type;

   function automatic word_type sat_word(input logic signed [SAT_W-1:0] x);
      word_type r;
      if (x > WORD_MAX_L) begin
         r = WORD_MAX;
      end else if (x < WORD_MIN_L) begin
         r = WORD_MIN;
      end else begin
         r = x[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

[hdl/bes_if.sv]
interface bes_req_if;
   logic        valid;
   logic        ready;
   logic        body_active;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic [30:0] half_height;
   logic [16:0] bounce_factor;
   logic [23:0] damping_rate;

   modport source (
      output valid, body_active, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
             half_height, bounce_factor, damping_rate,
      input  ready
   );
   modport sink (
      input  valid, body_active, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
             half_height, bounce_factor, damping_rate,
      output ready
   );
endinterface

interface bes_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_pos_z;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic signed [31:0] new_vel_z;
   logic        floor_contact;
   logic [30:0] impact_speed;

   modport source (
      output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
             floor_contact, impact_speed,
      input  ready
   );
   modport sink (
      input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
             floor_contact, impact_speed,
      output ready
   );
endinterface

[hdl/body_euler_step_with_floor_bounce.sv]
// One semi-implicit Euler step per body, with a floor at y = 0.
// req_chan takes one body state per item (valid/ready); rsp_chan returns the
// updated state, a floor contact flag and the impact speed, one item per item
// in, in order.
// Gravity and dt are set through the csr_ port (index, data, write enable);
// write them only while no item is in flight.
// The datapath is an eight stage pipeline: gravity and damping products,
// velocity update, damping multiply, damped velocity, position multiply,
// position update and floor test, restitution and friction multiply, output
// register. One item is taken every cycle while the receiver keeps up; the
// multipliers at every second stage set the depth.
// Each stage holds its item until the next stage frees up, so bubbles are
// squeezed out; when rsp_chan.ready stays low the pipe fills and req_chan.ready
// drops after at most eight more items. Nothing is lost or repeated.
// Synchronous reset empties the pipe and loads gravity (0, -9.81, 0) and
// dt = 1092 / 65536 s.
module body_euler_step_with_floor_bounce #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   bes_req_if.sink                          req_chan,
   bes_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [bes_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bes_pkg::WORD_W-1:0]       csr_wdata
);
   import bes_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   body_in_type body_in;
   logic        vel_valid, vel_ready, pos_valid, pos_ready;
   vel_out_type vel_data;
   pos_out_type pos_data;
   rsp_out_type rsp_data;

   always_comb begin
      cfg_in = cfg_ff;
      unique case (csr_index_type'(csr_index))
         CSR_GRAVITY_X: cfg_in.gravity_x = csr_wdata;
         CSR_GRAVITY_Y: cfg_in.gravity_y = csr_wdata;
         CSR_GRAVITY_Z: cfg_in.gravity_z = csr_wdata;
         CSR_TIME_STEP: cfg_in.time_step = csr_wdata[DT_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      body_in.body_active   = req_chan.body_active;
      body_in.pos[0]        = req_chan.pos_x;
      body_in.pos[1]        = req_chan.pos_y;
      body_in.pos[2]        = req_chan.pos_z;
      body_in.vel[0]        = req_chan.vel_x;
      body_in.vel[1]        = req_chan.vel_y;
      body_in.vel[2]        = req_chan.vel_z;
      body_in.half_height   = req_chan.half_height;
      body_in.bounce_factor = req_chan.bounce_factor;
      body_in.damping_rate  = req_chan.damping_rate;
   end

   bes_velocity #(.FRACTION_BITS(FRACTION_BITS)) u_velocity (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (body_in),
      .out_valid (vel_valid),
      .out_ready (vel_ready),
      .out_data  (vel_data)
   );

   bes_position u_position (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (vel_valid),
      .in_ready  (vel_ready),
      .in_data   (vel_data),
      .out_valid (pos_valid),
      .out_ready (pos_ready),
      .out_data  (pos_data)
   );

   bes_contact #(.FRACTION_BITS(FRACTION_BITS)) u_contact (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pos_valid),
      .in_ready  (pos_ready),
      .in_data   (pos_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.new_pos_x     = rsp_data.pos[0];
   assign rsp_chan.new_pos_y     = rsp_data.pos[1];
   assign rsp_chan.new_pos_z     = rsp_data.pos[2];
   assign rsp_chan.new_vel_x     = rsp_data.vel[0];
   assign rsp_chan.new_vel_y     = rsp_data.vel[1];
   assign rsp_chan.new_vel_z     = rsp_data.vel[2];
   assign rsp_chan.floor_contact = rsp_data.floor_contact;
   assign rsp_chan.impact_speed  = rsp_data.impact_speed;

   // an empty output register frees every stage, so the input must be open
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("input stalled with an empty output stage");

   a_contact_has_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.floor_contact |-> rsp_chan.impact_speed != '0)
      else $error("floor contact without impact speed");

   a_no_contact_no_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.floor_contact |-> rsp_chan.impact_speed == '0)
      else $error("impact speed without floor contact");

   a_bounce_goes_up: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.floor_contact
         |-> !rsp_chan.new_vel_y[WORD_W-1] && !rsp_chan.new_pos_y[WORD_W-1])
      else $error("bounced body moving down or below the floor");

endmodule

[hdl/bes_velocity.sv]
module bes_velocity #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bes_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bes_pkg::body_in_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bes_pkg::vel_out_type out_data
);
   import bes_pkg::*;

   localparam int KW  = FRACTION_BITS + 1;
   localparam int KPW = WORD_W + KW + 1;

   logic en1, en2, en3, en4;
   logic s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in;
   logic s3_vld_ff, s3_vld_in, s4_vld_ff, s4_vld_in;

   word_type grav [3];

   // stage 1: gravity and damping products
   body_in_type                 s1_body_ff;
   logic signed [MUL_DT_W-1:0]  s1_gdt_ff [3];
   logic signed [MUL_DT_W-1:0]  s1_gdt_in [3];
   logic [PROD_W-1:0]           s1_prod_ff, s1_prod_in;
   logic                        s1_damp_en_ff, s1_damp_en_in;

   // stage 2: velocity plus gravity, damping scale
   body_in_type                 s2_body_ff;
   word_type                    s2_vel_ff [3];
   word_type                    s2_vel_in [3];
   logic [KW-1:0]               s2_k_ff, s2_k_in;
   logic                        s2_damp_en_ff;
   logic [WORD_W:0]             k_diff;

   // stage 3: velocity times scale
   body_in_type                 s3_body_ff;
   word_type                    s3_vel_ff [3];
   logic signed [KPW-1:0]       s3_vk_ff [3];
   logic signed [KPW-1:0]       s3_vk_in [3];
   logic                        s3_damp_en_ff;

   // stage 4: damped velocity
   vel_out_type                 s4_ff, s4_in;

   assign en4 = !s4_vld_ff || out_ready;
   assign en3 = !s3_vld_ff || en4;
   assign en2 = !s2_vld_ff || en3;
   assign en1 = !s1_vld_ff || en2;
   assign in_ready = en1;

   assign s1_vld_in = en1 ? in_valid  : s1_vld_ff;
   assign s2_vld_in = en2 ? s1_vld_ff : s2_vld_ff;
   assign s3_vld_in = en3 ? s2_vld_ff : s3_vld_ff;
   assign s4_vld_in = en4 ? s3_vld_ff : s4_vld_ff;

   assign grav[0] = cfg.gravity_x;
   assign grav[1] = cfg.gravity_y;
   assign grav[2] = cfg.gravity_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // inactive bodies get no gravity, so their velocity passes unchanged
         if (in_data.body_active) begin
            s1_gdt_in[i] = grav[i] * $signed({1'b0, cfg.time_step});
         end else begin
            s1_gdt_in[i] = '0;
         end
      end
      s1_prod_in    = PROD_W'(in_data.damping_rate) * PROD_W'(cfg.time_step);
      s1_damp_en_in = in_data.body_active && (in_data.damping_rate != '0);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_vel_in[i] = sat_word(SAT_W'($signed(s1_body_ff.vel[i]))
                                 + SAT_W'(s1_gdt_ff[i] >>> DT_W));
      end
      // k = 1.0 - damping * dt, in Q1.F, zero once the product reaches 1.0
      k_diff  = {1'b1, {WORD_W{1'b0}}} - {1'b0, s1_prod_ff[WORD_W-1:0]};
      s2_k_in = (s1_prod_ff[PROD_W-1:WORD_W] == '0) ? k_diff[WORD_W -: KW] : '0;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_vk_in[i] = $signed(s2_vel_ff[i]) * $signed({1'b0, s2_k_ff});
      end
   end

   always_comb begin
      s4_in.body_active   = s3_body_ff.body_active;
      s4_in.pos           = s3_body_ff.pos;
      s4_in.half_height   = s3_body_ff.half_height;
      s4_in.bounce_factor = s3_body_ff.bounce_factor;
      for (int i = 0; i < 3; i++) begin
         s4_in.vel[i] = s3_damp_en_ff
                        ? sat_word(SAT_W'(s3_vk_ff[i] >>> FRACTION_BITS)) : s3_vel_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         s4_vld_ff <= s4_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_body_ff    <= in_data;
         s1_gdt_ff     <= s1_gdt_in;
         s1_prod_ff    <= s1_prod_in;
         s1_damp_en_ff <= s1_damp_en_in;
      end
      if (en2) begin
         s2_body_ff    <= s1_body_ff;
         s2_vel_ff     <= s2_vel_in;
         s2_k_ff       <= s2_k_in;
         s2_damp_en_ff <= s1_damp_en_ff;
      end
      if (en3) begin
         s3_body_ff    <= s2_body_ff;
         s3_vel_ff     <= s2_vel_ff;
         s3_vk_ff      <= s3_vk_in;
         s3_damp_en_ff <= s2_damp_en_ff;
      end
      if (en4) begin
         s4_ff <= s4_in;
      end
   end

   assign out_valid = s4_vld_ff;
   assign out_data  = s4_ff;

endmodule

[hdl/bes_position.sv]
module bes_position (
   input  logic                 clock,
   input  logic                 reset,
   input  bes_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bes_pkg::vel_out_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bes_pkg::pos_out_type out_data
);
   import bes_pkg::*;

   logic en5, en6;
   logic s5_vld_ff, s5_vld_in, s6_vld_ff, s6_vld_in;

   vel_out_type                s5_body_ff;
   logic signed [MUL_DT_W-1:0] s5_vdt_ff [3];
   logic signed [MUL_DT_W-1:0] s5_vdt_in [3];

   pos_out_type                s6_ff, s6_in;
   word_type                   p_new [3];
   logic                       below;
   logic [WORD_W:0]            neg_vy;

   assign en6 = !s6_vld_ff || out_ready;
   assign en5 = !s5_vld_ff || en6;
   assign in_ready = en5;

   assign s5_vld_in = en5 ? in_valid  : s5_vld_ff;
   assign s6_vld_in = en6 ? s5_vld_ff : s6_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (in_data.body_active) begin
            s5_vdt_in[i] = $signed(in_data.vel[i]) * $signed({1'b0, cfg.time_step});
         end else begin
            s5_vdt_in[i] = '0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_new[i] = sat_word(SAT_W'($signed(s5_body_ff.pos[i]))
                             + SAT_W'(s5_vdt_ff[i] >>> DT_W));
      end
      // bottom of the body below the floor
      below = s5_body_ff.body_active
              && ($signed({p_new[1][WORD_W-1], p_new[1]})
                  < $signed({2'b00, s5_body_ff.half_height}));
      neg_vy = '0 - {s5_body_ff.vel[1][WORD_W-1], s5_body_ff.vel[1]};

      s6_in.pos[0]        = p_new[0];
      s6_in.pos[1]        = below ? {1'b0, s5_body_ff.half_height} : p_new[1];
      s6_in.pos[2]        = p_new[2];
      s6_in.vel           = s5_body_ff.vel;
      s6_in.contact       = below && s5_body_ff.vel[1][WORD_W-1];
      s6_in.speed         = neg_vy[WORD_W-1:0];
      s6_in.bounce_factor = s5_body_ff.bounce_factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s5_vld_in;
         s6_vld_ff <= s6_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_body_ff <= in_data;
         s5_vdt_ff  <= s5_vdt_in;
      end
      if (en6) begin
         s6_ff <= s6_in;
      end
   end

   assign out_valid = s6_vld_ff;
   assign out_data  = s6_ff;

endmodule

[hdl/bes_contact.sv]
module bes_contact #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bes_pkg::pos_out_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bes_pkg::rsp_out_type out_data
);
   import bes_pkg::*;

   localparam longint C07_L = ((longint'(7) <<< FRACTION_BITS) + 5) / 10;
   localparam logic [FRACTION_BITS-1:0] C07 = FRACTION_BITS'(C07_L);
   localparam int CPW = WORD_W + FRACTION_BITS + 1;
   localparam int BSW = BOUNCE_PROD_W - BOUNCE_FRAC;

   logic en7, en8;
   logic s7_vld_ff, s7_vld_in, s8_vld_ff, s8_vld_in;

   pos_out_type                 s7_ff;
   logic [BOUNCE_PROD_W-1:0]    s7_by_ff, s7_by_in;
   logic signed [CPW-1:0]       s7_cx_ff, s7_cx_in, s7_cz_ff, s7_cz_in;

   rsp_out_type                 s8_ff, s8_in;
   logic [BSW-1:0]              by_sh;
   word_type                    vy_bounce;

   assign en8 = !s8_vld_ff || out_ready;
   assign en7 = !s7_vld_ff || en8;
   assign in_ready = en7;

   assign s7_vld_in = en7 ? in_valid  : s7_vld_ff;
   assign s8_vld_in = en8 ? s7_vld_ff : s8_vld_ff;

   always_comb begin
      s7_by_in = BOUNCE_PROD_W'(in_data.speed) * BOUNCE_PROD_W'(in_data.bounce_factor);
      s7_cx_in = $signed(in_data.vel[0]) * $signed({1'b0, C07});
      s7_cz_in = $signed(in_data.vel[2]) * $signed({1'b0, C07});
   end

   always_comb begin
      by_sh     = s7_by_ff[BOUNCE_PROD_W-1:BOUNCE_FRAC];
      vy_bounce = (by_sh[BSW-1:WORD_W-1] != '0) ? WORD_MAX : by_sh[WORD_W-1:0];

      s8_in.pos           = s7_ff.pos;
      s8_in.floor_contact = s7_ff.contact;
      if (s7_ff.contact) begin
         // reflected vertical speed, horizontal friction of 0.7
         s8_in.vel[0]       = sat_word(SAT_W'(s7_cx_ff >>> FRACTION_BITS));
         s8_in.vel[1]       = vy_bounce;
         s8_in.vel[2]       = sat_word(SAT_W'(s7_cz_ff >>> FRACTION_BITS));
         s8_in.impact_speed = s7_ff.speed[WORD_W-1] ? '1 : s7_ff.speed[HALF_W-1:0];
      end else begin
         s8_in.vel          = s7_ff.vel;
         s8_in.impact_speed = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
      end else begin
         s7_vld_ff <= s7_vld_in;
         s8_vld_ff <= s8_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         s7_ff    <= in_data;
         s7_by_ff <= s7_by_in;
         s7_cx_ff <= s7_cx_in;
         s7_cz_ff <= s7_cz_in;
      end
      if (en8) begin
         s8_ff <= s8_in;
      end
   end

   assign out_valid = s8_vld_ff;
   assign out_data  = s8_ff;

endmodule
